// ===== hw/rtl/dmcf_pkg.sv =====
// Shared types, register codes and arithmetic constants of the directional median chroma filter.
`default_nettype none

package dmcf_pkg;

    localparam int MAX_WIDTH_DEF = 4096;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_AMOUNT = 2'd2;

    // Item operation codes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Q16 luma weights, full blend and output ceiling.
    localparam int WT_R     = 13933;
    localparam int WT_G     = 46871;
    localparam int WT_B     = 4732;
    localparam int AMT_FULL = 65536;
    localparam int PIX_MAX  = 16383;

    typedef struct packed {
        logic        operation;
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic        frame_last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
    } t_rgb;

    // 3x3 neighborhood, index = row * 3 + column, row 0 is the upper row.
    typedef t_rgb [8:0] t_window;

endpackage

`default_nettype wire

// ===== hw/rtl/dmcf_line_store.sv =====
// Upper and middle row memories of the filter, one read and one write port each.
`default_nettype none

module dmcf_line_store #(
    parameter int DEPTH = dmcf_pkg::MAX_WIDTH_DEF,
    parameter int AW    = 12
) (
    input  wire logic            i_clk,
    input  wire logic            i_rd_en,
    input  wire logic [AW-1:0]   i_rd_addr,
    output dmcf_pkg::t_rgb       o_rd_up,
    output dmcf_pkg::t_rgb       o_rd_mid,
    input  wire logic            i_wr_en,
    input  wire logic [AW-1:0]   i_wr_addr,
    input  wire dmcf_pkg::t_rgb  i_wr_up,
    input  wire dmcf_pkg::t_rgb  i_wr_mid
);

    dmcf_pkg::t_rgb r_mem_up  [DEPTH];
    dmcf_pkg::t_rgb r_mem_mid [DEPTH];
    dmcf_pkg::t_rgb r_rd_up;
    dmcf_pkg::t_rgb r_rd_mid;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_up  <= r_mem_up[i_rd_addr];
            r_rd_mid <= r_mem_mid[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem_up[i_wr_addr]  <= i_wr_up;
            r_mem_mid[i_wr_addr] <= i_wr_mid;
        end
    end

    assign o_rd_up  = r_rd_up;
    assign o_rd_mid = r_rd_mid;

endmodule

`default_nettype wire

// ===== hw/rtl/dmcf_correct.sv =====
// Direction search and luma-preserving chroma blend for one inner pixel.
`default_nettype none

module dmcf_correct (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire dmcf_pkg::t_window  i_win,
    input  wire logic [16:0]        i_amount,
    output logic                    o_done,
    output dmcf_pkg::t_rgb          o_rgb
);

    localparam logic [3:0] E_IDLE = 4'd0;
    localparam logic [3:0] E_SQ   = 4'd1;
    localparam logic [3:0] E_CMP  = 4'd2;
    localparam logic [3:0] E_MUL  = 4'd3;
    localparam logic [3:0] E_NR   = 4'd4;
    localparam logic [3:0] E_WT   = 4'd5;
    localparam logic [3:0] E_GQ   = 4'd6;
    localparam logic [3:0] E_SUM  = 4'd7;
    localparam logic [3:0] E_RND  = 4'd8;

    localparam logic signed [15:0] KR = 16'(dmcf_pkg::WT_R);
    localparam logic signed [15:0] KB = 16'(dmcf_pkg::WT_B);

    function automatic logic signed [16:0] chroma(input logic [15:0] c, input logic [15:0] g);
        return $signed({1'b0, c}) - $signed({1'b0, g});
    endfunction

    function automatic logic signed [16:0] med3(input logic signed [16:0] a,
                                                input logic signed [16:0] b,
                                                input logic signed [16:0] c);
        logic signed [16:0] lo;
        logic signed [16:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c < lo) begin
            return lo;
        end else if (c > hi) begin
            return hi;
        end
        return c;
    endfunction

    function automatic logic [15:0] rnd(input logic signed [55:0] v);
        logic signed [55:0] s;
        logic [23:0]        q;
        s = v + 56'sd2147483648;
        q = s[55:32];
        if (v <= 56'sd0) begin
            return 16'd0;
        end else if (q > 24'(dmcf_pkg::PIX_MAX)) begin
            return 16'(dmcf_pkg::PIX_MAX);
        end
        return q[15:0];
    endfunction

    logic [3:0]            r_state;
    logic [1:0]            r_dir;
    logic [35:0]           r_sqr;
    logic [35:0]           r_sqb;
    logic signed [16:0]    r_mr;
    logic signed [16:0]    r_mb;
    logic [36:0]           r_best;
    logic signed [16:0]    r_br;
    logic signed [16:0]    r_bb;
    logic signed [35:0]    r_pr;
    logic signed [35:0]    r_pb;
    logic [32:0]           r_luma;
    logic signed [37:0]    r_nr;
    logic signed [37:0]    r_nb;
    logic signed [55:0]    r_tr;
    logic signed [55:0]    r_tb;
    logic signed [55:0]    r_gq;
    logic signed [55:0]    r_vr;
    logic signed [55:0]    r_vb;
    logic                  r_done;
    dmcf_pkg::t_rgb        r_rgb;

    logic                  n_done;

    dmcf_pkg::t_rgb        cen;
    dmcf_pkg::t_rgb        na;
    dmcf_pkg::t_rgb        nb;
    logic signed [16:0]    rc;
    logic signed [16:0]    bc;
    logic signed [16:0]    mr;
    logic signed [16:0]    mb;
    logic signed [17:0]    dr;
    logic signed [17:0]    db;
    logic [36:0]           dd;
    logic                  better;
    logic [36:0]           n_best;
    logic signed [17:0]    dbr;
    logic signed [17:0]    dbb;

    assign cen = i_win[4];
    assign rc  = chroma(cen.r, cen.g);
    assign bc  = chroma(cen.b, cen.g);

    always_comb begin
        unique case (r_dir)
            2'd0: begin na = i_win[3]; nb = i_win[5]; end
            2'd1: begin na = i_win[1]; nb = i_win[7]; end
            2'd2: begin na = i_win[0]; nb = i_win[8]; end
            2'd3: begin na = i_win[2]; nb = i_win[6]; end
            default: begin na = i_win[3]; nb = i_win[5]; end
        endcase
    end

    assign mr = med3(chroma(na.r, na.g), rc, chroma(nb.r, nb.g));
    assign mb = med3(chroma(na.b, na.g), bc, chroma(nb.b, nb.g));
    assign dr = 18'(mr) - 18'(rc);
    assign db = 18'(mb) - 18'(bc);

    assign dd     = {1'b0, r_sqr} + {1'b0, r_sqb};
    assign better = (r_dir == 2'd0) || (dd < r_best);
    assign n_best = better ? dd : r_best;
    assign dbr    = 18'(r_br) - 18'(rc);
    assign dbb    = 18'(r_bb) - 18'(bc);

    assign n_done = (r_state == E_RND)
                 || ((r_state == E_CMP) && (r_dir == 2'd3) && (n_best == 37'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_dir   <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= n_done;
            unique case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        r_dir   <= 2'd0;
                        r_state <= E_SQ;
                    end
                end
                E_SQ: begin
                    r_sqr   <= 36'(dr * dr);
                    r_sqb   <= 36'(db * db);
                    r_mr    <= mr;
                    r_mb    <= mb;
                    r_state <= E_CMP;
                end
                E_CMP: begin
                    r_best <= n_best;
                    if (better) begin
                        r_br <= r_mr;
                        r_bb <= r_mb;
                    end
                    if (r_dir == 2'd3) begin
                        if (n_best == 37'd0) begin
                            // The pixel already sits on its best median.
                            r_rgb   <= cen;
                            r_state <= E_IDLE;
                        end else begin
                            r_state <= E_MUL;
                        end
                    end else begin
                        r_dir   <= r_dir + 2'd1;
                        r_state <= E_SQ;
                    end
                end
                E_MUL: begin
                    r_pr    <= $signed({1'b0, i_amount}) * dbr;
                    r_pb    <= $signed({1'b0, i_amount}) * dbb;
                    r_luma  <= 33'(dmcf_pkg::WT_R) * 33'(cen.r)
                             + 33'(dmcf_pkg::WT_G) * 33'(cen.g)
                             + 33'(dmcf_pkg::WT_B) * 33'(cen.b);
                    r_state <= E_NR;
                end
                E_NR: begin
                    r_nr    <= (38'(rc) <<< 16) + 38'(r_pr);
                    r_nb    <= (38'(bc) <<< 16) + 38'(r_pb);
                    r_state <= E_WT;
                end
                E_WT: begin
                    r_tr    <= 56'(r_nr) * 56'(KR);
                    r_tb    <= 56'(r_nb) * 56'(KB);
                    r_state <= E_GQ;
                end
                E_GQ: begin
                    r_gq    <= ($signed(56'(r_luma)) <<< 16) - r_tr - r_tb;
                    r_state <= E_SUM;
                end
                E_SUM: begin
                    r_vr    <= r_gq + (56'(r_nr) <<< 16);
                    r_vb    <= r_gq + (56'(r_nb) <<< 16);
                    r_state <= E_RND;
                end
                E_RND: begin
                    r_rgb.r <= rnd(r_vr);
                    r_rgb.g <= rnd(r_gq);
                    r_rgb.b <= rnd(r_vb);
                    r_state <= E_IDLE;
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rgb  = r_rgb;

endmodule

`default_nettype wire

// ===== hw/rtl/directional_median_chroma_filter_unit.sv =====
// Top level of the directional median chroma filter: control, counters, window, output register.
//
// Pixels of a frame enter in raster order on the input channel (i_in_valid, o_in_stall,
// i_in_data); each leaves on the output channel (o_out_valid, i_out_stall, o_out_data)
// after frame_width + 1 further pixel items. Drain items, sent once the frame is complete,
// push out the pending tail one pixel each. Registers are written on the configuration
// channel (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data) while the block is idle;
// a width or height write restarts the frame position.
// One item is worked at a time. The two row memories are read at a transfer and written back
// in the cycle after it. An item that yields no result then returns to idle; a border or
// drained pixel passes on to the output push; a corrected inner pixel first waits for the
// four-direction search and the multiply chain of the correction unit, which end early when
// the search finds the pixel already on its median.
// The output register lets the next item enter while a result waits; a stalled receiver
// holds that result, and a further result then waits inside the block, which keeps the
// input stalled until the output register frees. The input is also stalled while a
// configuration write is offered. Reset clears the counters and control state; row
// memory contents are not cleared.
`default_nettype none

module directional_median_chroma_filter_unit #(
    parameter int MAX_WIDTH = dmcf_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire dmcf_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output dmcf_pkg::t_out_item       o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [16:0]          i_cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2(MAX_WIDTH + 2);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]           r_state;
    logic [12:0]          r_fw;
    logic [15:0]          r_fh;
    logic [16:0]          r_amt;
    logic [AW-1:0]        r_in_col;
    logic [15:0]          r_in_row;
    logic [AW-1:0]        r_out_col;
    logic [15:0]          r_out_row;
    logic [PW-1:0]        r_pend;
    logic                 r_op;
    logic                 r_emit;
    logic                 r_inner;
    logic                 r_last;
    logic                 r_sel_up;
    logic [AW-1:0]        r_addr;
    dmcf_pkg::t_rgb       r_pix;
    dmcf_pkg::t_window    r_win;
    dmcf_pkg::t_rgb       r_res;
    logic                 r_ovalid;
    dmcf_pkg::t_out_item  r_opay;
    logic                 r_start;

    logic [AW-1:0]        n_in_col;
    logic [15:0]          n_in_row;
    logic [AW-1:0]        n_out_col;
    logic [15:0]          n_out_row;
    logic [PW-1:0]        n_pend;
    logic                 n_ovalid;
    logic                 n_start;

    logic [31:0]          fw32;
    logic [WW-1:0]        w_eff;
    logic [15:0]          h_eff;
    logic                 in_acc;
    logic                 cfg_acc;
    logic                 is_drain;
    logic                 emit;
    logic                 inner;
    logic                 last;
    logic [WW-1:0]        in_inc;
    logic [16:0]          in_row_inc;
    logic [WW-1:0]        out_inc;
    logic [16:0]          out_row_inc;
    logic [AW-1:0]        rd_addr;
    logic                 push_ok;
    dmcf_pkg::t_rgb       rd_up;
    dmcf_pkg::t_rgb       rd_mid;
    logic                 eng_done;
    dmcf_pkg::t_rgb       eng_rgb;

    // A width of zero acts as one; anything above the memory depth is cut to it.
    assign fw32  = {19'd0, r_fw};
    assign w_eff = (r_fw == 13'd0) ? WW'(1)
                 : (fw32 > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : fw32[WW-1:0];
    assign h_eff = (r_fh == 16'd0) ? 16'd1 : r_fh;

    assign o_in_stall  = (r_state != ST_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign is_drain    = (i_in_data.operation == dmcf_pkg::OP_DRAIN);

    assign emit = is_drain
                ? ((r_pend != '0) && (r_in_col == '0) && (r_in_row == 16'd0))
                : (32'(r_pend) >= 32'(w_eff) + 32'd1);

    assign inner = (r_amt != 17'd0) && (32'(w_eff) >= 32'd3) && (h_eff >= 16'd3)
                && (r_out_row != 16'd0) && (32'(r_out_row) + 32'd2 <= 32'(h_eff))
                && (r_out_col != '0) && (32'(r_out_col) + 32'd2 <= 32'(w_eff));
    assign last  = (32'(r_out_row) == 32'(h_eff) - 32'd1)
                && (32'(r_out_col) == 32'(w_eff) - 32'd1);

    assign in_inc      = WW'(r_in_col) + WW'(1);
    assign in_row_inc  = {1'b0, r_in_row} + 17'd1;
    assign out_inc     = WW'(r_out_col) + WW'(1);
    assign out_row_inc = {1'b0, r_out_row} + 17'd1;

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_pend    = r_pend;
        if (!is_drain) begin
            if (in_inc >= w_eff) begin
                n_in_col = '0;
                n_in_row = (in_row_inc >= {1'b0, h_eff}) ? 16'd0 : in_row_inc[15:0];
            end else begin
                n_in_col = in_inc[AW-1:0];
            end
        end
        if (emit) begin
            if (out_inc >= w_eff) begin
                n_out_col = '0;
                n_out_row = (out_row_inc >= {1'b0, h_eff}) ? 16'd0 : out_row_inc[15:0];
            end else begin
                n_out_col = out_inc[AW-1:0];
            end
        end
        if (!is_drain && !emit) begin
            n_pend = r_pend + PW'(1);
        end else if (is_drain && emit) begin
            n_pend = r_pend - PW'(1);
        end
    end

    // A drained pixel is read from the row memory at its own column.
    assign rd_addr = is_drain ? r_out_col : r_in_col;
    assign push_ok = !r_ovalid || !i_out_stall;

    assign n_start  = (r_state == ST_READ) && r_emit && (r_op == dmcf_pkg::OP_PIXEL)
                   && r_inner;
    assign n_ovalid = ((r_state == ST_PUSH) && push_ok) || (r_ovalid && i_out_stall);

    dmcf_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_lines (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (rd_addr),
        .o_rd_up   (rd_up),
        .o_rd_mid  (rd_mid),
        .i_wr_en   ((r_state == ST_READ) && (r_op == dmcf_pkg::OP_PIXEL)),
        .i_wr_addr (r_addr),
        .i_wr_up   (rd_mid),
        .i_wr_mid  (r_pix)
    );

    dmcf_correct u_correct (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_win    (r_win),
        .i_amount (r_amt),
        .o_done   (eng_done),
        .o_rgb    (eng_rgb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fw      <= 13'd4096;
            r_fh      <= 16'd1;
            r_amt     <= 17'd0;
            r_in_col  <= '0;
            r_in_row  <= 16'd0;
            r_out_col <= '0;
            r_out_row <= 16'd0;
            r_pend    <= '0;
            r_ovalid  <= 1'b0;
            r_start   <= 1'b0;
        end else begin
            r_start  <= n_start;
            r_ovalid <= n_ovalid;
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    dmcf_pkg::CFG_WIDTH: begin
                        r_fw      <= i_cfg_data[12:0];
                        r_in_col  <= '0;
                        r_in_row  <= 16'd0;
                        r_out_col <= '0;
                        r_out_row <= 16'd0;
                        r_pend    <= '0;
                    end
                    dmcf_pkg::CFG_HEIGHT: begin
                        r_fh      <= i_cfg_data[15:0];
                        r_in_col  <= '0;
                        r_in_row  <= 16'd0;
                        r_out_col <= '0;
                        r_out_row <= 16'd0;
                        r_pend    <= '0;
                    end
                    dmcf_pkg::CFG_AMOUNT: begin
                        r_amt <= (i_cfg_data > 17'(dmcf_pkg::AMT_FULL))
                               ? 17'(dmcf_pkg::AMT_FULL) : i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end else begin
                unique case (r_state)
                    ST_IDLE: begin
                        if (in_acc) begin
                            r_in_col  <= n_in_col;
                            r_in_row  <= n_in_row;
                            r_out_col <= n_out_col;
                            r_out_row <= n_out_row;
                            r_pend    <= n_pend;
                            r_state   <= ST_READ;
                        end
                    end
                    ST_READ: begin
                        if (!r_emit) begin
                            r_state <= ST_IDLE;
                        end else if (r_op == dmcf_pkg::OP_DRAIN) begin
                            r_res   <= r_sel_up ? rd_up : rd_mid;
                            r_state <= ST_PUSH;
                        end else if (!r_inner) begin
                            r_res   <= r_win[5];
                            r_state <= ST_PUSH;
                        end else begin
                            r_state <= ST_WAIT;
                        end
                    end
                    ST_WAIT: begin
                        if (eng_done) begin
                            r_res   <= eng_rgb;
                            r_state <= ST_PUSH;
                        end
                    end
                    ST_PUSH: begin
                        if (push_ok) begin
                            r_state <= ST_IDLE;
                        end
                    end
                    default: r_state <= ST_IDLE;
                endcase
            end
        end
    end

    // Item context and window; payload registers without reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= i_in_data.operation;
            r_emit   <= emit;
            r_inner  <= inner && !is_drain;
            r_last   <= last;
            r_sel_up <= (32'(r_pend) == 32'(w_eff) + 32'd1);
            r_addr   <= rd_addr;
            r_pix    <= '{r: i_in_data.red_in, g: i_in_data.green_in, b: i_in_data.blue_in};
        end
        if ((r_state == ST_READ) && (r_op == dmcf_pkg::OP_PIXEL)) begin
            // Shift in the new column: two rows back, one row back, the new pixel.
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= rd_up;
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[5] <= rd_mid;
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[8] <= r_pix;
        end
        if ((r_state == ST_PUSH) && push_ok) begin
            r_opay <= '{red_out: r_res.r, green_out: r_res.g, blue_out: r_res.b,
                        frame_last: r_last};
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_opay;

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pend) <= 32'(w_eff) + 32'd1)
        else $error("pending pixel count exceeds the row delay");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_in_col) < 32'(w_eff))
        else $error("input column outside the frame width");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_done |-> (r_state == ST_WAIT))
        else $error("correction finished while control was not waiting for it");

    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !cfg_acc) |=> (r_state == ST_READ))
        else $error("accepted item did not start its memory read");

endmodule

`default_nettype wire
